[design/fin_pkg.sv]
package fin_pkg;

	localparam logic [31:0] MAGIC_CONST = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
	localparam logic [31:0] F_HALF      = 32'h3f000000;
	localparam logic [31:0] F_ONE_HALF  = 32'h3fc00000;

	typedef logic [31:0] fp32_t;

	// round-to-nearest-even single multiply, subnormals supported
	function automatic fp32_t fmul(input fp32_t a, input fp32_t b);
		logic        sa, sb, sr;
		logic [7:0]  ea, eb;
		logic [22:0] ma, mb;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [23:0] fa, fb;
		logic [47:0] prod;
		logic signed [10:0] exp_a, exp_b, e;
		logic [5:0]  lz;
		logic [47:0] norm;
		logic [49:0] wide;
		logic [6:0]  rsh;
		logic        sticky, guard, lsb;
		logic [24:0] mant;
		fp32_t       r;
		integer      i;
		sa = a[31]; sb = b[31]; sr = sa ^ sb;
		ea = a[30:23]; eb = b[30:23];
		ma = a[22:0]; mb = b[22:0];
		a_nan = (ea == 8'hff) && (ma != 23'd0);
		b_nan = (eb == 8'hff) && (mb != 23'd0);
		a_inf = (ea == 8'hff) && (ma == 23'd0);
		b_inf = (eb == 8'hff) && (mb == 23'd0);
		a_zero = (ea == 8'd0) && (ma == 23'd0);
		b_zero = (eb == 8'd0) && (mb == 23'd0);
		fa = {(ea != 8'd0), ma};
		fb = {(eb != 8'd0), mb};
		exp_a = (ea == 8'd0) ? 11'sd1 : $signed({3'd0, ea});
		exp_b = (eb == 8'd0) ? 11'sd1 : $signed({3'd0, eb});
		prod = fa * fb;
		lz = 6'd0;
		for (i = 0; i < 48; i++) begin
			if (prod[i]) lz = 6'(47 - i);
		end
		norm = prod << lz;
		// value = norm * 2^(e-127-47), with leading one at bit 47
		e = exp_a + exp_b - 11'sd126 - $signed({5'd0, lz});
		r = 32'd0;
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			r = CANON_NAN;
		end else if (a_inf || b_inf) begin
			r = {sr, 8'hff, 23'd0};
		end else if (a_zero || b_zero) begin
			r = {sr, 31'd0};
		end else begin
			if (e < 11'sd1) begin
				rsh = (11'sd1 - e > 11'sd49) ? 7'd49 : 7'(11'sd1 - e);
				e = 11'sd0;
			end else begin
				rsh = 7'd0;
			end
			wide = {norm, 2'b00} >> rsh;
			sticky = (({norm, 2'b00} & ~({50{1'b1}} << rsh)) != 50'd0)
				|| (wide[24:0] != 25'd0);
			guard = wide[25];
			lsb = wide[26];
			mant = {1'b0, wide[49:26]} + {24'd0, (guard && (sticky || lsb))};
			if (e == 11'sd0) begin
				if (mant[23]) e = 11'sd1;
			end else if (mant[24]) begin
				mant = mant >> 1;
				e = e + 11'sd1;
			end
			if (e >= 11'sd255) r = {sr, 8'hff, 23'd0};
			else r = {sr, e[7:0], mant[22:0]};
		end
		return r;
	endfunction

	// round-to-nearest-even single add
	function automatic fp32_t fadd(input fp32_t a, input fp32_t b);
		logic        a_nan, b_nan, a_inf, b_inf;
		logic [7:0]  ea, eb, el;
		logic [26:0] xa, xb, xs, shifted;
		logic [7:0]  d;
		logic        sl, ss, sr;
		logic [27:0] sum;
		logic [4:0]  lz;
		logic signed [9:0] e;
		logic [27:0] n;
		logic        sticky;
		logic [24:0] mant;
		fp32_t       r, big, sml;
		integer      i;
		a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		if (a[30:0] >= b[30:0]) begin big = a; sml = b; end
		else begin big = b; sml = a; end
		ea = big[30:23]; eb = sml[30:23];
		sl = big[31]; ss = sml[31];
		el = (ea == 8'd0) ? 8'd1 : ea;
		d = el - ((eb == 8'd0) ? 8'd1 : eb);
		xa = {1'b0, (ea != 8'd0), big[22:0], 2'b00};
		xb = {1'b0, (eb != 8'd0), sml[22:0], 2'b00};
		if (d > 8'd26) begin
			shifted = 27'd0;
			sticky = (xb != 27'd0);
		end else begin
			shifted = xb >> d;
			sticky = ((xb & ~({27{1'b1}} << d)) != 27'd0);
		end
		xs = shifted;
		if (sl == ss) sum = {xa, 1'b0} + {xs, sticky};
		else sum = {xa, 1'b0} - {xs, sticky};
		r = 32'd0;
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
			r = CANON_NAN;
		end else if (a_inf || b_inf) begin
			r = a_inf ? a : b;
		end else if (sum == 28'd0) begin
			sr = (a[31] && b[31]);
			r = {sr, 31'd0};
		end else begin
			// sum: bit27 carry, bit26 hidden, bits 2:0 guard/round/sticky
			e = $signed({2'd0, el});
			if (sum[27]) begin
				n = {1'b0, sum[27:2], sum[1] | sum[0]};
				e = e + 10'sd1;
			end else begin
				lz = 5'd0;
				for (i = 0; i < 27; i++) begin
					if (sum[i]) lz = 5'(26 - i);
				end
				if ($signed({5'd0, lz}) > e - 10'sd1) lz = 5'(e - 10'sd1);
				n = sum << lz;
				e = e - $signed({5'd0, lz});
			end
			// n[26] hidden, n[25:3] mantissa, n[2] guard, n[1:0] sticky
			mant = {1'b0, n[26:3]} + {24'd0, n[2] && ((n[1:0] != 2'd0) || n[3])};
			if (mant[24]) begin
				mant = mant >> 1;
				e = e + 10'sd1;
			end
			if (!mant[23]) e = 10'sd0;
			if (e >= 10'sd255) r = {sl, 8'hff, 23'd0};
			else r = {sl, e[7:0], mant[22:0]};
		end
		return r;
	endfunction

	function automatic fp32_t canon(input fp32_t f);
		if ((f[30:23] == 8'hff) && (f[22:0] != 23'd0)) return CANON_NAN;
		return f;
	endfunction

endpackage

[design/fin_sumsq.sv]
module fin_sumsq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         v_in,
	input  logic         quat,
	input  fin_pkg::fp32_t c0, c1, c2, c3,
	output logic         v_s4,
	output fin_pkg::fp32_t sum_s4
);
	import fin_pkg::*;

	fp32_t p0_s1, p1_s1, p2_s1, p3_s1;
	fp32_t a01_s2, p2_s2, p3_s2;
	fp32_t a012_s3, p3_s3;
	logic  v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1 <= fmul(c0, c0);
			p1_s1 <= fmul(c1, c1);
			p2_s1 <= fmul(c2, c2);
			p3_s1 <= quat ? fmul(c3, c3) : 32'h80000000;
			a01_s2 <= fadd(p0_s1, p1_s1);
			p2_s2 <= p2_s1;
			p3_s2 <= p3_s1;
			a012_s3 <= fadd(a01_s2, p2_s2);
			p3_s3 <= p3_s2;
			sum_s4 <= fadd(a012_s3, p3_s3);
		end
	end
endmodule

[design/fin_rsqrt.sv]
module fin_rsqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         v_in,
	input  fin_pkg::fp32_t s,
	output logic         v_out,
	output fin_pkg::fp32_t r_out
);
	import fin_pkg::*;

	fp32_t half_s5, y_s5, hy_s6, y_s6, t_s7, y_s7, d_s8, y_s8;
	logic  v_s5, v_s6, v_s7, v_s8;
	logic [31:0] sh;

	assign sh = {s[31], s[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_out <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_in; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_out <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s5 <= fmul(F_HALF, s);
			y_s5 <= MAGIC_CONST - sh;
			hy_s6 <= fmul(half_s5, y_s5);
			y_s6 <= y_s5;
			t_s7 <= fmul(hy_s6, y_s6);
			y_s7 <= y_s6;
			d_s8 <= fadd(F_ONE_HALF, {~t_s7[31], t_s7[30:0]});
			y_s8 <= y_s7;
			r_out <= fmul(y_s8, d_s8);
		end
	end
endmodule

[design/fast_invsqrt_normalizer_top.sv]
// fast inverse square root normalizer
// input channel: valid/stall with command (0 vector, 1 quaternion) and
// comp_0..comp_3 ieee single bit patterns; one transaction per cycle while in_stall is low.
// output channel: out_valid/out_stall with norm_0..norm_3.
// ten register stages: squares, three sum adds, magic estimate and half,
// two newton multiplies, newton subtract, newton multiply, component scaling.
// throughput is one transaction per cycle with no stall.
// a stall on the output freezes the whole pipeline; in_stall follows
// out_stall while the last stage holds a result, so nothing is lost.
// in vector mode norm_3 is zero. nan results are the canonical quiet nan.
// reset clears all valid bits; no result is produced until new input.
module fast_invsqrt_normalizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] comp_0,
	input  logic [31:0] comp_1,
	input  logic [31:0] comp_2,
	input  logic [31:0] comp_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] norm_0,
	output logic [31:0] norm_1,
	output logic [31:0] norm_2,
	output logic [31:0] norm_3
);
	import fin_pkg::*;

	logic  adv;
	logic  v4, v9;
	fp32_t s4, r9;
	fp32_t c_q [9][4];
	logic  quat_q [9];

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	fin_sumsq u_sum (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(in_valid), .quat(command),
		.c0(comp_0), .c1(comp_1), .c2(comp_2), .c3(comp_3),
		.v_s4(v4), .sum_s4(s4)
	);

	fin_rsqrt u_rs (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v4), .s(s4),
		.v_out(v9), .r_out(r9)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			c_q[0] <= '{comp_0, comp_1, comp_2, comp_3};
			quat_q[0] <= command;
			for (int k = 1; k < 9; k++) begin
				c_q[k] <= c_q[k-1];
				quat_q[k] <= quat_q[k-1];
			end
			norm_0 <= canon(fmul(c_q[8][0], r9));
			norm_1 <= canon(fmul(c_q[8][1], r9));
			norm_2 <= canon(fmul(c_q[8][2], r9));
			norm_3 <= quat_q[8] ? canon(fmul(c_q[8][3], r9)) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v9;
		end
	end
endmodule
